// ===== hw/rtl/egbr_pkg.sv =====
`default_nettype none

package egbr_pkg;

	// Function codes on the request channel
	localparam logic [2:0] FUNC_RESTART = 3'd0;
	localparam logic [2:0] FUNC_LOAD    = 3'd1;
	localparam logic [2:0] FUNC_FIXED   = 3'd2;
	localparam logic [2:0] FUNC_UE      = 3'd3;
	localparam logic [2:0] FUNC_SE      = 3'd4;

	// Datapath geometry
	localparam int BYTE_BITS  = 8;
	localparam int WIN_BITS   = 64;
	localparam int BANKS      = WIN_BITS / BYTE_BITS;
	localparam int BANK_BITS  = $clog2(BANKS);
	localparam int FIELD_BITS = 32;
	localparam int CNT_BITS   = 6;
	localparam int AVW        = $clog2(WIN_BITS + 1);
	localparam int VAL_BITS   = 33;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPW         = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		OP_RESTART,
		OP_LOAD,
		OP_FIXED,
		OP_UE,
		OP_SE
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [BYTE_BITS-1:0]  data_byte;
		logic [CNT_BITS-1:0]   bit_count;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

`default_nettype wire

// ===== hw/rtl/egbr_if.sv =====
`default_nettype none

interface egbr_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] data_byte;
	logic [5:0] bit_count;

	modport source (output valid, func, data_byte, bit_count, input ready);
	modport sink (input valid, func, data_byte, bit_count, output ready);
endinterface

interface egbr_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [32:0] value;
	logic               at_end;
	logic               too_long;

	modport source (output valid, value, at_end, too_long, input ready);
	modport sink (input valid, value, at_end, too_long, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/egbr_front.sv =====
`default_nettype none

module egbr_front import egbr_pkg::*; (
	egbr_req_if.sink req,
	input  logic     full,
	output logic     push,
	output cmd_t     push_cmd
);

	logic known;
	op_t  op;

	// Decode the function code; unknown codes are taken and dropped
	always_comb begin
		known = 1'b1;
		op    = OP_RESTART;
		unique case (req.func)
			FUNC_RESTART: op = OP_RESTART;
			FUNC_LOAD:    op = OP_LOAD;
			FUNC_FIXED:   op = OP_FIXED;
			FUNC_UE:      op = OP_UE;
			FUNC_SE:      op = OP_SE;
			default:      known = 1'b0;
		endcase
	end

	// Accept whenever the queue has room
	assign req.ready = !full;
	assign push      = req.valid && !full && known;

	// Clamp the field width to the widest fixed read
	always_comb begin
		push_cmd.op        = op;
		push_cmd.data_byte = req.data_byte;
		push_cmd.bit_count = (req.bit_count > CNT_BITS'(FIELD_BITS)) ?
			CNT_BITS'(FIELD_BITS) : req.bit_count;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/egbr_queue.sv =====
`default_nettype none

module egbr_queue import egbr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	output logic    full,
	input  logic    pop,
	output q_head_t head
);

	cmd_t                         entry_q [QUEUE_DEPTH];
	logic [QPW-1:0]               wr_ptr_q;
	logic [QPW-1:0]               rd_ptr_q;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] count_q;

	assign full       = (count_q == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/egbr_store.sv =====
`default_nettype none

module egbr_store import egbr_pkg::*; #(
	parameter int BUF_BYTES = 4096
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(BUF_BYTES+1)-1:0]   wr_idx,
	input  logic [BYTE_BITS-1:0]             wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(BUF_BYTES+1)-1:0]   rd_base,
	output logic [WIN_BITS-1:0]              win
);

	localparam int TW   = $clog2(BUF_BYTES + 1);
	localparam int ROWS = (BUF_BYTES + BANKS - 1) / BANKS;
	localparam int RW   = $clog2(ROWS);

	logic [RW-1:0]            wr_row;
	logic [TW-1:0]            base_row;
	logic [BANK_BITS-1:0]     base_lo_q;
	logic [WIN_BITS-1:0]      lin;
	logic [2*WIN_BITS-1:0]    dbl;

	assign wr_row   = RW'(wr_idx >> BANK_BITS);
	assign base_row = rd_base >> BANK_BITS;

	// One byte-wide bank per byte lane; consecutive bytes sit in consecutive banks
	for (genvar j = 0; j < BANKS; j++) begin : g_bank
		logic [BYTE_BITS-1:0] mem [ROWS];
		logic [BYTE_BITS-1:0] rdata_q;
		logic                 bump;
		logic [RW-1:0]        rd_row;

		// Banks below the start lane take the byte from the next row
		assign bump   = (BANK_BITS'(j) < rd_base[BANK_BITS-1:0]);
		assign rd_row = RW'(base_row + {{(TW-1){1'b0}}, bump});

		always_ff @(posedge clk) begin
			if (wr_en && wr_idx[BANK_BITS-1:0] == BANK_BITS'(j)) mem[wr_row] <= wr_data;
			if (rd_en) rdata_q <= mem[rd_row];
		end

		assign lin[WIN_BITS-1-BYTE_BITS*j -: BYTE_BITS] = rdata_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) base_lo_q <= rd_base[BANK_BITS-1:0];
	end

	// Rotate bank order so the start byte lands at the top
	assign dbl = {lin, lin} << {base_lo_q, 3'b000};
	assign win = dbl[2*WIN_BITS-1 -: WIN_BITS];

endmodule

`default_nettype wire

// ===== hw/rtl/egbr_back.sv =====
`default_nettype none

module egbr_back import egbr_pkg::*; #(
	parameter int BUF_BYTES  = 4096,
	parameter int MAX_PREFIX = 31
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  q_head_t                          head,
	output logic                             pop,
	output logic                             wr_en,
	output logic [$clog2(BUF_BYTES+1)-1:0]   wr_idx,
	output logic [BYTE_BITS-1:0]             wr_data,
	output logic                             rd_en,
	output logic [$clog2(BUF_BYTES+1)-1:0]   rd_base,
	input  logic [WIN_BITS-1:0]              win,
	egbr_rsp_if.source                       rsp
);

	localparam int TW = $clog2(BUF_BYTES + 1);
	localparam int PW = TW + 3;
	localparam int EW = PW + 1;
	localparam int W  = MAX_PREFIX + 1;
	localparam int ZW = $clog2(W);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_FIX  = 4'b0010,
		ST_PFX  = 4'b0100,
		ST_SFX  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [TW-1:0]         total_q;
	logic [PW-1:0]         pos_q;
	logic [CNT_BITS-1:0]   n_q;
	logic [ZW-1:0]         z_q;
	logic                  is_se_q;
	logic                  out_valid_q;
	logic [VAL_BITS-1:0]   value_q;
	logic                  at_end_q;
	logic                  too_long_q;

	logic [PW-1:0]          t_bits;
	logic                   past;
	logic [PW-1:0]          diff;
	logic [AVW-1:0]         avail;
	logic [WIN_BITS-1:0]    mask;
	logic [WIN_BITS-1:0]    aligned;
	logic [FIELD_BITS-1:0]  top;
	logic [W-1:0]           pre;
	logic                   out_free;
	logic                   room;
	logic                   emit;

	logic [FIELD_BITS-1:0]  fix_val;
	logic [EW-1:0]          fix_sum;
	logic                   fix_end;
	logic [PW-1:0]          fix_pos;

	logic                   one_found;
	logic [ZW-1:0]          zc;
	logic [AVW-1:0]         z1;
	logic                   hit_end;
	logic                   need_sfx;
	logic [EW-1:0]          pfx_next;
	logic [PW-1:0]          sfx_base;
	logic [PW-1:0]          pfx_pos;
	logic                   pfx_long;

	logic [FIELD_BITS-1:0]  suf;
	logic [VAL_BITS-1:0]    k;
	logic [VAL_BITS-1:0]    se_val;
	logic [EW-1:0]          sfx_sum;
	logic                   sfx_end;
	logic [PW-1:0]          sfx_pos;

	logic [VAL_BITS-1:0]    res_value;
	logic                   res_at_end;
	logic                   res_long;

	// Bits left in the buffer, clamped to the window
	assign t_bits = {total_q, 3'b000};
	assign past   = (pos_q >= t_bits);
	assign diff   = t_bits - pos_q;
	assign avail  = past ? '0 :
		((diff >= PW'(WIN_BITS)) ? AVW'(WIN_BITS) : AVW'(diff));

	// Align the window to the read position and zero bits past the end
	assign mask    = ~({WIN_BITS{1'b1}} >> avail);
	assign aligned = (win << pos_q[2:0]) & mask;
	assign top     = aligned[WIN_BITS-1 -: FIELD_BITS];
	assign pre     = aligned[WIN_BITS-1 -: W];

	// Fixed-width field
	assign fix_val = top >> (CNT_BITS'(FIELD_BITS) - n_q);
	assign fix_sum = EW'(pos_q) + EW'(n_q);
	assign fix_end = (fix_sum >= EW'(t_bits));
	assign fix_pos = fix_end ? t_bits : PW'(fix_sum);

	// Count leading zeros of the code prefix
	always_comb begin
		zc = '0;
		for (int i = 0; i < W; i++) begin
			if (pre[i]) zc = ZW'(W - 1 - i);
		end
	end

	assign one_found = |pre;
	assign z1        = AVW'(zc) + AVW'(1);
	assign hit_end   = one_found ? (z1 >= avail) : (avail <= AVW'(W));
	assign need_sfx  = one_found && !hit_end && (zc != '0);
	assign pfx_next  = EW'(pos_q) + EW'(zc) + EW'(1);
	assign sfx_base  = PW'(pfx_next);
	assign pfx_long  = !one_found && !hit_end;
	assign pfx_pos   = hit_end ? t_bits :
		(one_found ? (pos_q + PW'(1)) : (pos_q + PW'(W)));

	// Code suffix and signed mapping
	assign suf     = top >> (CNT_BITS'(FIELD_BITS) - CNT_BITS'(z_q));
	assign k       = (VAL_BITS'(1) << z_q) - VAL_BITS'(1) + VAL_BITS'(suf);
	assign se_val  = k[0] ? ((k + VAL_BITS'(1)) >> 1) : (VAL_BITS'(0) - (k >> 1));
	assign sfx_sum = EW'(pos_q) + EW'(z_q);
	assign sfx_end = (sfx_sum >= EW'(t_bits));
	assign sfx_pos = sfx_end ? t_bits : PW'(sfx_sum);

	// Handshake with the queue, the store and the output register
	assign out_free = !out_valid_q || rsp.ready;
	assign room     = (total_q < TW'(BUF_BYTES));
	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign wr_en    = pop && (head.cmd.op == OP_LOAD) && room;
	assign wr_idx   = total_q;
	assign wr_data  = head.cmd.data_byte;
	assign rd_en    = (pop && (head.cmd.op inside {OP_FIXED, OP_UE, OP_SE})) ||
		((state_q == ST_PFX) && need_sfx);
	assign rd_base  = (state_q == ST_IDLE) ? pos_q[PW-1:3] : sfx_base[PW-1:3];
	assign emit     = out_free && ((state_q == ST_FIX) || (state_q == ST_SFX) ||
		((state_q == ST_PFX) && !need_sfx));

	// Select the result of the finishing step
	always_comb begin
		res_value  = '0;
		res_at_end = 1'b0;
		res_long   = 1'b0;
		unique case (state_q)
			ST_FIX: begin
				res_value  = VAL_BITS'(fix_val);
				res_at_end = fix_end;
			end
			ST_PFX: begin
				res_at_end = hit_end;
				res_long   = pfx_long;
			end
			ST_SFX: begin
				res_value  = is_se_q ? se_val : k;
				res_at_end = sfx_end;
			end
			default: ;
		endcase
	end

	// Sequence the commands and track buffer fill and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			if (emit) out_valid_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						unique case (head.cmd.op) inside
							OP_RESTART: begin
								total_q <= '0;
								pos_q   <= '0;
							end
							OP_LOAD: begin
								if (room) total_q <= total_q + TW'(1);
							end
							OP_FIXED: state_q <= ST_FIX;
							OP_UE, OP_SE: state_q <= ST_PFX;
							default: ;
						endcase
					end
				end
				ST_FIX: begin
					if (out_free) begin
						pos_q   <= fix_pos;
						state_q <= ST_IDLE;
					end
				end
				ST_PFX: begin
					if (need_sfx) begin
						pos_q   <= sfx_base;
						state_q <= ST_SFX;
					end else if (out_free) begin
						pos_q   <= pfx_pos;
						state_q <= ST_IDLE;
					end
				end
				ST_SFX: begin
					if (out_free) begin
						pos_q   <= sfx_pos;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold item operands and the result
	always_ff @(posedge clk) begin
		if (pop) begin
			n_q     <= head.cmd.bit_count;
			is_se_q <= (head.cmd.op == OP_SE);
		end
		if (state_q == ST_PFX) z_q <= zc;
		if (emit) begin
			value_q    <= res_value;
			at_end_q   <= res_at_end;
			too_long_q <= res_long;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.value    = $signed(value_q);
	assign rsp.at_end   = at_end_q;
	assign rsp.too_long = too_long_q;

endmodule

`default_nettype wire

// ===== hw/rtl/exp_golomb_bit_reader_unit.sv =====
// A fixed read passes through the queue, a registered window fetch from the banked byte
// store and the output register; a code read fetches once more for its suffix.
// Restart and load finish in the back end's idle state. The back end takes the next
// command only once the last read is done, and a stalled output holds it back.
// Reset clears the fill count, read position, queue and output valid; buffer bytes are
// undefined until loaded, and no clearing pass runs.
`default_nettype none

module exp_golomb_bit_reader_unit import egbr_pkg::*; #(
	parameter int BUF_BYTES  = 4096,
	parameter int MAX_PREFIX = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	egbr_req_if.sink   req,
	egbr_rsp_if.source rsp
);

	localparam int TW = $clog2(BUF_BYTES + 1);

	logic                 full;
	logic                 push;
	cmd_t                 push_cmd;
	logic                 pop;
	q_head_t              head;
	logic                 wr_en;
	logic [TW-1:0]        wr_idx;
	logic [BYTE_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [TW-1:0]        rd_base;
	logic [WIN_BITS-1:0]  win;

	egbr_front u_front (
		.req      (req),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	egbr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head)
	);

	egbr_store #(
		.BUF_BYTES (BUF_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_base (rd_base),
		.win     (win)
	);

	egbr_back #(
		.BUF_BYTES  (BUF_BYTES),
		.MAX_PREFIX (MAX_PREFIX)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_base (rd_base),
		.win     (win),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/egbr_chk.sv =====
`default_nettype none

module egbr_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        rsp_valid,
	input wire        rsp_ready,
	input wire [32:0] rsp_value,
	input wire        rsp_at_end,
	input wire        rsp_too_long
);

	// Hold a stalled result unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
		$stable(rsp_at_end) && $stable(rsp_too_long))
		else $error("result changed while stalled");

	// An overlong prefix decodes to zero
	a_long_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_too_long |-> rsp_value == 33'd0)
		else $error("overlong prefix gave a nonzero value");

	// An overlong prefix stops short of the end of data
	a_long_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_too_long |-> !rsp_at_end)
		else $error("overlong prefix flagged at end of data");

	// Negative signed codes stay within 32-bit magnitude
	a_neg_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_value[32] |-> rsp_value[31] && !rsp_too_long)
		else $error("negative value out of range");

endmodule

bind exp_golomb_bit_reader_unit egbr_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_value    (rsp.value),
	.rsp_at_end   (rsp.at_end),
	.rsp_too_long (rsp.too_long)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
	import egbr_pkg::*;

	localparam int STORE_BYTES   = 4096;
	localparam int PREFIX_LIMIT  = 31;
	localparam int RANDOM_ITEMS  = 820;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 120;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_LIMIT  = 10;

	// func values the block ignores
	localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

	// two maximal codes behind a prefix that is one zero too long
	localparam logic [7:0] CODE_BYTES [20] = '{
		8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	typedef struct {
		logic [2:0] func;
		logic [7:0] data_byte;
		logic [5:0] bit_count;
		bit         hold;
	} cmd_item_t;

	typedef struct {
		logic [32:0] value;
		logic        at_end;
		logic        too_long;
	} read_result_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic [2:0] req_func  = FUNC_RESTART;
	logic [7:0] req_data  = '0;
	logic [5:0] req_count = '0;
	logic       rsp_ready = 1'b0;
	logic       req_taken = 1'b0;

	egbr_req_if req ();
	egbr_rsp_if rsp ();

	assign req.valid     = req_valid;
	assign req.func      = req_func;
	assign req.data_byte = req_data;
	assign req.bit_count = req_count;
	assign rsp.ready     = rsp_ready;

	exp_golomb_bit_reader_unit #(
		.BUF_BYTES (STORE_BYTES),
		.MAX_PREFIX(PREFIX_LIMIT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	cmd_item_t    cmd_q[$];
	read_result_t expected_reads[$];

	// reader state as seen by the prediction
	logic [7:0]  store_img [STORE_BYTES];
	int unsigned fill_bytes = 0;
	int unsigned rd_byte    = 0;
	int unsigned rd_bit     = 0;

	int unsigned real_items   = 0;
	int unsigned results_seen = 0;
	int unsigned errors       = 0;
	int unsigned n_load = 0, n_drop = 0, n_restart = 0, n_ignored = 0;
	int unsigned n_fixed = 0, n_ue = 0, n_se = 0, n_long = 0, n_end = 0;

	int unsigned burst_left   = 1;
	int unsigned gap_left     = 0;
	int unsigned rx_tick      = 0;
	int unsigned hold_left    = 0;
	bit          hold_used    = 1'b0;
	int unsigned stall_cycles = 0;

	// queue one command; fields the command does not use get random values
	function void queue_item(logic [2:0] func, logic [7:0] data_byte,
			logic [5:0] bit_count, bit hold);
		cmd_item_t it;
		it.func      = func;
		it.data_byte = (func == FUNC_LOAD) ? data_byte : 8'($urandom);
		it.bit_count = (func == FUNC_FIXED) ? bit_count : 6'($urandom);
		it.hold      = hold;
		cmd_q.push_back(it);
		if (func <= FUNC_SE)
			real_items++;
	endfunction

	// take one bit MSB first; past the end it reads as 0 and does not move
	function automatic bit pull_bit();
		bit b;
		if (rd_byte >= fill_bytes || rd_byte >= STORE_BYTES)
			return 1'b0;
		b = store_img[rd_byte][7 - rd_bit];
		rd_bit++;
		if (rd_bit == 8) begin
			rd_bit = 0;
			rd_byte++;
		end
		return b;
	endfunction

	function automatic logic [63:0] pull_field(int unsigned n);
		logic [63:0] v;
		v = '0;
		for (int unsigned i = 0; i < n; i++)
			v = {v[62:0], pull_bit()};
		return v;
	endfunction

	// decode one Exp-Golomb code number
	function automatic logic [63:0] pull_code(output bit overlong);
		int unsigned zeros;
		bit          b;
		bit          done;
		bit          hit_end;
		zeros    = 0;
		done     = 1'b0;
		hit_end  = 1'b0;
		overlong = 1'b0;
		while (!done) begin
			b = pull_bit();
			if (rd_byte >= fill_bytes) begin
				hit_end = 1'b1;
				done    = 1'b1;
			end else if (b) begin
				done = 1'b1;
			end else begin
				zeros++;
				if (zeros > PREFIX_LIMIT) begin
					overlong = 1'b1;
					done     = 1'b1;
				end
			end
		end
		if (hit_end || overlong || zeros == 0)
			return '0;
		return ((64'd1 << zeros) - 64'd1) + pull_field(zeros);
	endfunction

	// advance the reader by one command and work out its result, if any
	function automatic bit reader_step(logic [2:0] func, logic [7:0] data_byte,
			logic [5:0] bit_count, output read_result_t res);
		logic [63:0] v;
		logic [63:0] k;
		bit          overlong;
		overlong = 1'b0;
		res      = '{default: '0};
		case (func)
			FUNC_RESTART: begin
				fill_bytes = 0;
				rd_byte    = 0;
				rd_bit     = 0;
				n_restart++;
				return 1'b0;
			end
			FUNC_LOAD: begin
				n_load++;
				if (fill_bytes < STORE_BYTES) begin
					store_img[fill_bytes] = data_byte;
					fill_bytes++;
				end else begin
					n_drop++;
				end
				return 1'b0;
			end
			FUNC_FIXED: begin
				v = pull_field((bit_count > 6'd32) ? 32 : int'(bit_count));
				n_fixed++;
			end
			FUNC_UE: begin
				v = pull_code(overlong);
				n_ue++;
			end
			FUNC_SE: begin
				k = pull_code(overlong);
				v = k[0] ? ((k + 64'd1) >> 1) : (64'd0 - (k >> 1));
				n_se++;
			end
			default: begin
				n_ignored++;
				return 1'b0;
			end
		endcase
		res.value    = v[32:0];
		res.at_end   = (rd_byte >= fill_bytes);
		res.too_long = overlong;
		if (overlong)
			n_long++;
		if (res.at_end)
			n_end++;
		return 1'b1;
	endfunction

	function void flag_error(string what);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
	endfunction

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// sender: bursts of items with random gaps, hold items wait for an empty pipe
	always @(negedge clk) begin : feed
		cmd_item_t it;
		if (arst_n && !(req_valid && !req_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (cmd_q.size() != 0 &&
					!(cmd_q[0].hold && expected_reads.size() != 0)) begin
				it = cmd_q.pop_front();
				req_func  <= it.func;
				req_data  <= it.data_byte;
				req_count <= it.bit_count;
				req_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern that steps through its modes as rx_tick advances, plus one long hold-off
	always @(negedge clk) begin : sink_side
		if (arst_n) begin
			rx_tick++;
			if (!hold_used && results_seen >= HOLD_AFTER) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				case ((rx_tick >> 6) % 6)
					0, 1:    rsp_ready <= 1'b1;
					2:       rsp_ready <= 1'($urandom_range(0, 1));
					3:       rsp_ready <= ($urandom_range(0, 3) == 0);
					4:       rsp_ready <= 1'(rx_tick >> 2);
					default: rsp_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// check results against the oldest expectation, predict accepted items
	always @(posedge clk) begin : observe
		read_result_t got;
		read_result_t want;
		read_result_t pred;
		if (arst_n) begin
			req_taken <= req_valid && req.ready;
			if (rsp.valid && rsp_ready) begin
				results_seen++;
				got.value    = rsp.value;
				got.at_end   = rsp.at_end;
				got.too_long = rsp.too_long;
				if (expected_reads.size() == 0) begin
					flag_error($sformatf("result with nothing expected: value %h at_end %b too_long %b",
						got.value, got.at_end, got.too_long));
				end else begin
					want = expected_reads.pop_front();
					if (got.value !== want.value)
						flag_error($sformatf("value expected %h got %h", want.value, got.value));
					if (got.at_end !== want.at_end)
						flag_error($sformatf("at_end expected %b got %b", want.at_end, got.at_end));
					if (got.too_long !== want.too_long)
						flag_error($sformatf("too_long expected %b got %b",
							want.too_long, got.too_long));
				end
			end
			if (req_valid && req.ready) begin
				if (reader_step(req_func, req_data, req_count, pred))
					expected_reads.push_back(pred);
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((req_valid && req.ready) || (rsp.valid && rsp_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		bit          bits[$];
		cmd_item_t   plan[$];
		cmd_item_t   op;
		int unsigned rand_base;
		int unsigned segs;
		int unsigned kind;
		int unsigned zeros;
		int unsigned width;
		logic [7:0]  octet;
		bit          first_session;

		// directed: overlong prefix, largest ue and se codes, end of data cases
		queue_item(FUNC_RESTART, '0, '0, 1'b0);
		foreach (CODE_BYTES[i])
			queue_item(FUNC_LOAD, CODE_BYTES[i], '0, 1'b0);
		queue_item(FUNC_UE, '0, '0, 1'b0);
		queue_item(FUNC_UE, '0, '0, 1'b0);
		queue_item(FUNC_SE, '0, '0, 1'b0);
		queue_item(FUNC_SE, '0, '0, 1'b0);
		queue_item(FUNC_SE, '0, '0, 1'b0);
		queue_item(FUNC_FIXED, '0, 6'd63, 1'b0);
		queue_item(FUNC_FIXED, '0, 6'd0, 1'b0);
		queue_item(FUNC_UE, '0, '0, 1'b0);

		// random sessions: mostly well-formed code streams read back in step
		rand_base     = real_items;
		first_session = 1'b1;
		while (real_items < rand_base + RANDOM_ITEMS) begin
			if (first_session || $urandom_range(0, 7) != 0)
				queue_item(FUNC_RESTART, '0, '0, first_session || $urandom_range(0, 9) == 0);
			first_session = 1'b0;
			bits.delete();
			plan.delete();
			segs = $urandom_range(1, 8);
			for (int s = 0; s < segs; s++) begin
				kind         = $urandom_range(0, 9);
				op.data_byte = '0;
				op.hold      = 1'b0;
				if (kind < 7) begin
					zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PREFIX_LIMIT + 1)
						: $urandom_range(0, 3);
					for (int i = 0; i < zeros; i++)
						bits.push_back(1'b0);
					if (zeros <= PREFIX_LIMIT) begin
						bits.push_back(1'b1);
						for (int i = 0; i < zeros; i++)
							bits.push_back(1'($urandom_range(0, 1)));
					end
					op.func      = (kind < 4) ? FUNC_UE : FUNC_SE;
					op.bit_count = '0;
				end else begin
					width = $urandom_range(0, 32);
					for (int i = 0; i < width; i++)
						bits.push_back(1'($urandom_range(0, 1)));
					op.func      = FUNC_FIXED;
					op.bit_count = (width == 32 && $urandom_range(0, 1))
						? 6'($urandom_range(33, 63)) : 6'(width);
				end
				plan.push_back(op);
			end
			while (bits.size() % 8 != 0)
				bits.push_back(1'($urandom_range(0, 1)));
			for (int i = 0; i < bits.size(); i += 8) begin
				for (int b = 0; b < 8; b++)
					octet[7 - b] = bits[i + b];
				queue_item(FUNC_LOAD, octet, '0, 1'b0);
			end
			foreach (plan[j]) begin
				if ($urandom_range(0, 19) == 0)
					queue_item(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), '0, '0, 1'b0);
				queue_item(plan[j].func, '0, plan[j].bit_count, 1'b0);
			end
			// occasionally read on past the data
			if ($urandom_range(0, 3) == 0) begin
				for (int i = $urandom_range(1, 2); i > 0; i--)
					queue_item(3'($urandom_range(FUNC_FIXED, FUNC_SE)), '0,
						6'($urandom), 1'b0);
			end
		end

		// release reset
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all items sent, all results back, then a settling margin
		while (cmd_q.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_reads.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_reads.size()));

		$display("covered %0d loads (%0d dropped at full buffer), %0d restarts, %0d ignored funcs",
			n_load, n_drop, n_restart, n_ignored);
		$display("checked %0d fixed, %0d ue, %0d se reads: %0d overlong, %0d at end; %0d errors",
			n_fixed, n_ue, n_se, n_long, n_end, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
